// ===== design/polyline_stroke_expander_top_defines.svh =====
// Assertion macros for the polyline stroke expander.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef POLYLINE_STROKE_EXPANDER_TOP_DEFINES_SVH
`define POLYLINE_STROKE_EXPANDER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pse assertion failed");

// next-cycle implication, disabled during reset
`define PSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pse assertion failed");

`endif

// ===== design/pse_pkg.sv =====
// Shared widths, codes, command/status types and rounding helper
// for the polyline stroke expander. No dependencies.
package pse_pkg;

  localparam int PT_W       = 16;
  localparam int SCL_W      = 16;
  localparam int THK_W      = 12;
  localparam int PROD_W     = 33;
  localparam int POS_W      = 28;
  localparam int DIF_W      = 29;
  localparam int MAG_W      = 28;
  localparam int SQ_W       = 56;
  localparam int SUM_W      = 57;
  localparam int LEN_W      = 29;
  localparam int TH_W       = 28;
  localparam int NUM_W      = 52;
  localparam int Q_W        = 24;
  localparam int OFS_W      = 25;
  localparam int VTX_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VERTS      = 4;
  localparam int VIDX_W     = 2;
  localparam int STEP_W     = 5;
  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 2'd2;

  localparam logic [THK_W-1:0] THK_RESET = 12'd16;
  localparam logic [SCL_W-1:0] SCL_RESET = 16'd256;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_LOAD,
    OP_ROUND,
    OP_DIFF,
    OP_SQUARE,
    OP_SUM,
    OP_SQRT_STEP,
    OP_PRODUCT,
    OP_NUMER,
    OP_DIV_STEP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [VIDX_W-1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic sum_zero;
    logic out_busy;
  } status_t;

  // Q.12 product to Q.8, half away from zero
  function automatic logic signed [POS_W-1:0] round16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r   = (mag + PROD_W'(8)) >> 4;
    return p[PROD_W-1] ? -$signed(r[POS_W-1:0]) : $signed(r[POS_W-1:0]);
  endfunction

endpackage

// ===== design/pse_ctrl.sv =====
// Sequencing state machine for the polyline stroke expander.
// Depends on pse_pkg; drives commands into pse_datapath.
module pse_ctrl
  import pse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_stroke_start,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROUND, S_DIFF, S_SQUARE, S_SUM, S_SQRT,
    S_PRODUCT, S_NUMER, S_DIV, S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [VIDX_W-1:0]   vidx_r, vidx_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    vidx_nxt  = vidx_r;
    cmd.op    = OP_NONE;
    cmd.vidx  = vidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_stroke_start || !status.have_prev) begin
            cmd.op = OP_STORE;
          end else begin
            cmd.op    = OP_LOAD;
            state_nxt = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.op    = OP_SQUARE;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          vidx_nxt  = '0;
          state_nxt = status.sum_zero ? S_EMIT : S_PRODUCT;
        end
      end
      S_PRODUCT: begin
        cmd.op    = OP_PRODUCT;
        state_nxt = S_NUMER;
      end
      S_NUMER: begin
        cmd.op    = OP_NUMER;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          vidx_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op   = OP_EMIT;
          vidx_nxt = vidx_r + VIDX_W'(1);
          if (vidx_r == VIDX_W'(VERTS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      vidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      vidx_r  <= vidx_nxt;
    end
  end

endmodule

// ===== design/pse_datapath.sv =====
// Datapath of the polyline stroke expander: config registers, scaling,
// shared square-root and divide steps, output register. Depends on pse_pkg.
module pse_datapath
  import pse_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [PT_W-1:0]      in_point_x,
  input  logic signed [PT_W-1:0]      in_point_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VTX_W-1:0]     out_vertex_x,
  output logic signed [VTX_W-1:0]     out_vertex_y,
  output logic                        out_last_vertex
);

  logic [THK_W-1:0]        thick_r;
  logic [SCL_W-1:0]        sx_r, sy_r;
  logic signed [PT_W-1:0]  prev_x_r, prev_y_r;
  logic                    have_prev_r;

  logic signed [PROD_W-1:0] px1_r, py1_r, px2_r, py2_r;
  logic signed [POS_W-1:0]  x1_r, y1_r, x2_r, y2_r;
  logic signed [DIF_W-1:0]  dx_r, dy_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r, mx_r, my_r;
  logic [TH_W-1:0]          tx_r, ty_r;
  logic [SUM_W-1:0]         rem_r, res_r, bit_r;
  logic                     sum_zero_r;
  logic [NUM_W-1:0]         rx_r, ry_r, dvs_r;
  logic [Q_W-1:0]           qx_r, qy_r;

  logic                     out_valid_r;
  logic signed [VTX_W-1:0]  vx_r, vy_r;
  logic                     last_r;

  logic [MAG_W-1:0]         magx, magy;
  logic [SUM_W-1:0]         trial;
  logic [LEN_W-1:0]         len;
  logic [SUM_W-1:0]         numx, numy;
  logic signed [OFS_W-1:0]  ofs_x, ofs_y;
  logic signed [POS_W-1:0]  base_x, base_y;
  logic signed [DIF_W-1:0]  sumx, sumy;

  assign magx  = dx_r[DIF_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
  assign magy  = dy_r[DIF_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);
  assign trial = res_r + bit_r;
  assign len   = res_r[LEN_W-1:0];
  assign numx  = (SUM_W'(mx_r) + (SUM_W'(len) << 4)) >> 5;
  assign numy  = (SUM_W'(my_r) + (SUM_W'(len) << 4)) >> 5;

  // nx takes the sign of -dy, ny the sign of dx
  assign ofs_x = !dy_r[DIF_W-1] ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
  assign ofs_y = dx_r[DIF_W-1] ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});

  always_comb begin
    base_x = cmd.vidx[1] ? x2_r : x1_r;
    base_y = cmd.vidx[1] ? y2_r : y1_r;
    if (cmd.vidx[0]) begin
      sumx = DIF_W'(base_x) - DIF_W'(ofs_x);
      sumy = DIF_W'(base_y) - DIF_W'(ofs_y);
    end else begin
      sumx = DIF_W'(base_x) + DIF_W'(ofs_x);
      sumy = DIF_W'(base_y) + DIF_W'(ofs_y);
    end
  end

  assign status.have_prev = have_prev_r;
  assign status.sum_zero  = sum_zero_r;
  assign status.out_busy  = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = vx_r;
  assign out_vertex_y    = vy_r;
  assign out_last_vertex = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r     <= THK_RESET;
      sx_r        <= SCL_RESET;
      sy_r        <= SCL_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THICKNESS: thick_r <= cfg_data[THK_W-1:0];
          REG_SCALE_X:   sx_r    <= cfg_data;
          REG_SCALE_Y:   sy_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_STORE || cmd.op == OP_LOAD) begin
        prev_x_r    <= in_point_x;
        prev_y_r    <= in_point_y;
        have_prev_r <= 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px1_r <= PROD_W'(prev_x_r) * $signed({1'b0, sx_r});
        py1_r <= PROD_W'(prev_y_r) * $signed({1'b0, sy_r});
        px2_r <= PROD_W'(in_point_x) * $signed({1'b0, sx_r});
        py2_r <= PROD_W'(in_point_y) * $signed({1'b0, sy_r});
      end
      OP_ROUND: begin
        x1_r <= round16(px1_r);
        y1_r <= round16(py1_r);
        x2_r <= round16(px2_r);
        y2_r <= round16(py2_r);
      end
      OP_DIFF: begin
        dx_r <= DIF_W'(x2_r) - DIF_W'(x1_r);
        dy_r <= DIF_W'(y2_r) - DIF_W'(y1_r);
      end
      OP_SQUARE: begin
        sqx_r <= SQ_W'(magx) * SQ_W'(magx);
        sqy_r <= SQ_W'(magy) * SQ_W'(magy);
        tx_r  <= TH_W'(thick_r) * TH_W'(sx_r);
        ty_r  <= TH_W'(thick_r) * TH_W'(sy_r);
      end
      OP_SUM: begin
        rem_r      <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
        sum_zero_r <= (sqx_r == '0) && (sqy_r == '0);
        res_r      <= '0;
        bit_r      <= SUM_W'(1) << (SUM_W - 1);
        qx_r       <= '0;
        qy_r       <= '0;
      end
      OP_SQRT_STEP: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_PRODUCT: begin
        mx_r <= SQ_W'(magy) * SQ_W'(tx_r);
        my_r <= SQ_W'(magx) * SQ_W'(ty_r);
      end
      OP_NUMER: begin
        rx_r  <= numx[NUM_W-1:0];
        ry_r  <= numy[NUM_W-1:0];
        dvs_r <= NUM_W'(len) << (Q_W - 1);
      end
      OP_DIV_STEP: begin
        if (rx_r >= dvs_r) begin
          rx_r <= rx_r - dvs_r;
          qx_r <= {qx_r[Q_W-2:0], 1'b1};
        end else begin
          qx_r <= {qx_r[Q_W-2:0], 1'b0};
        end
        if (ry_r >= dvs_r) begin
          ry_r <= ry_r - dvs_r;
          qy_r <= {qy_r[Q_W-2:0], 1'b1};
        end else begin
          qy_r <= {qy_r[Q_W-2:0], 1'b0};
        end
        dvs_r <= dvs_r >> 1;
      end
      OP_EMIT: begin
        vx_r   <= VTX_W'(sumx);
        vy_r   <= VTX_W'(sumy);
        last_r <= (cmd.vidx == VIDX_W'(VERTS - 1));
      end
      default: ;
    endcase
  end

endmodule

// ===== design/polyline_stroke_expander_top.sv =====
// Polyline stroke expander: each point after the first of a stroke yields
// four triangle-strip vertices (two per segment endpoint, last one marked).
// Input channel: in_valid/in_stall with in_point_x, in_point_y, in_stroke_start.
// Output channel: out_valid/out_stall with out_vertex_x/y, out_last_vertex.
// Configuration: cfg_we, cfg_index, cfg_data; thickness, scale x, scale y.
// A start point, or the first point after reset, is stored, no output.
// Other points: one multiply stage, rounding, difference, squaring, a sum,
// then a bit-serial square root, product and numerator steps and two
// parallel restoring dividers; the first vertex is then registered and
// the rest follow one per cycle while the receiver does not stall.
// in_stall is high after a transfer until the fourth vertex is loaded.
// A zero-length segment skips the product, numerator and divide steps
// and emits four copies of the point.
// A stalled receiver holds the output register; the sequencer waits in its
// emit state. Synchronous active-low reset restores the configuration
// registers to their defaults and forgets the previous point.
// Depends on pse_pkg, pse_ctrl, pse_datapath and the assertion macro header.
`include "polyline_stroke_expander_top_defines.svh"
module polyline_stroke_expander_top
  import pse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [PT_W-1:0]   in_point_x,
  input  logic signed [PT_W-1:0]   in_point_y,
  input  logic                     in_stroke_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VTX_W-1:0]  out_vertex_x,
  output logic signed [VTX_W-1:0]  out_vertex_y,
  output logic                     out_last_vertex
);

  cmd_t    cmd;
  status_t status;

  pse_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stroke_start (in_stroke_start),
    .in_stall        (in_stall),
    .status          (status),
    .cmd             (cmd)
  );

  pse_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_last_vertex (out_last_vertex)
  );

  `PSE_ASSERT_NOW(a_store_on_transfer, cmd.op == OP_STORE || cmd.op == OP_LOAD, in_valid && !in_stall)
  `PSE_ASSERT_NOW(a_emit_not_stalled, cmd.op == OP_EMIT, !(out_valid && out_stall))
  `PSE_ASSERT_NEXT(a_busy_after_load, cmd.op == OP_LOAD, in_stall)

endmodule
